FILE: hdl/ssh_pkg.sv
// ----------------------------------------------------------------------------
// ssh_pkg
// Shared types and constants for the sample statistics histogram block.
// ----------------------------------------------------------------------------
package ssh_pkg;

	localparam int DEF_MAX_SAMPLES = 1024;
	localparam int DEF_MAX_BINS    = 64;

	localparam int SAMPLE_W    = 16;
	localparam int BIN_COUNT_W = 7;
	localparam int INDEX_W     = 6;
	localparam int TALLY_W     = 11;

	localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_RST = 7'd10;
	localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_MIN = 7'd2;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SETUP,
		ST_RD,
		ST_MUL,
		ST_DIV,
		ST_DIV_WAIT,
		ST_CNT_RD,
		ST_CNT_WR,
		ST_AVG,
		ST_AVG_WAIT,
		ST_OUT_RD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic in_fire;
		logic last_in;
		logic empty;
		logic span_zero;
		logic div_done;
		logic last_idx;
		logic out_fire;
		logic last_bin;
	} sts_t;

	typedef struct packed {
		logic in_ready;
		logic setup;
		logic rd;
		logic mul;
		logic bin_start;
		logic bin_cap;
		logic cnt_rd;
		logic cnt_wr;
		logic avg_start;
		logic avg_cap;
		logic out_rd;
		logic out_valid;
	} ctl_t;

endpackage

FILE: hdl/ssh_divider.sv
// ----------------------------------------------------------------------------
// ssh_divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssh_divider #(
	parameter int W  = 32,
	parameter int QW = 16,
	parameter int SW = $clog2(QW + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [W-1:0]  dividend,
	input  logic [W-1:0]  divisor,
	input  logic [SW-1:0] steps,
	output logic          done,
	output logic [QW-1:0] quotient
);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  dsh_q;
	logic [QW-1:0] quo_q;
	logic [SW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic          fit;

	assign fit = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= W'(divisor << (steps - 1'b1));
			quo_q <= '0;
		end else if (run_q) begin
			if (fit) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QW-2:0], fit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: hdl/ssh_fsm.sv
// ----------------------------------------------------------------------------
// ssh_fsm
// Sequencer: load, bin each stored sample, average, then report bins.
// ----------------------------------------------------------------------------
module ssh_fsm
	import ssh_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  sts_t sts,
	output ctl_t ctl
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (sts.in_fire && sts.last_in) state_nxt = ST_SETUP;
			end
			ST_SETUP:    state_nxt = sts.empty ? ST_OUT_RD : ST_RD;
			ST_RD:       state_nxt = ST_MUL;
			ST_MUL:      state_nxt = ST_DIV;
			ST_DIV:      state_nxt = sts.span_zero ? ST_CNT_RD : ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (sts.div_done) state_nxt = ST_CNT_RD;
			end
			ST_CNT_RD:   state_nxt = ST_CNT_WR;
			ST_CNT_WR:   state_nxt = sts.last_idx ? ST_AVG : ST_RD;
			ST_AVG:      state_nxt = ST_AVG_WAIT;
			ST_AVG_WAIT: begin
				if (sts.div_done) state_nxt = ST_OUT_RD;
			end
			ST_OUT_RD:   state_nxt = ST_OUT;
			ST_OUT: begin
				if (sts.out_fire) state_nxt = sts.last_bin ? ST_LOAD : ST_OUT_RD;
			end
			default:     state_nxt = ST_LOAD;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			ST_LOAD:     ctl.in_ready  = 1'b1;
			ST_SETUP:    ctl.setup     = 1'b1;
			ST_RD:       ctl.rd        = 1'b1;
			ST_MUL:      ctl.mul       = 1'b1;
			ST_DIV:      ctl.bin_start = 1'b1;
			ST_DIV_WAIT: ctl.bin_cap   = 1'b1;
			ST_CNT_RD:   ctl.cnt_rd    = 1'b1;
			ST_CNT_WR:   ctl.cnt_wr    = 1'b1;
			ST_AVG:      ctl.avg_start = 1'b1;
			ST_AVG_WAIT: ctl.avg_cap   = 1'b1;
			ST_OUT_RD:   ctl.out_rd    = 1'b1;
			ST_OUT:      ctl.out_valid = 1'b1;
			default:     ctl = '0;
		endcase
	end

endmodule

FILE: hdl/sample_stats_histogram_top.sv
// ----------------------------------------------------------------------------
// sample_stats_histogram_top
// Equal-width histogram of a sample set with its minimum, maximum and mean.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready) takes one Q0.16 sample per request;
//    in_ready stays high while loading, so a set streams at one sample/cycle.
//  - The request with last_sample ends the set. in_ready then drops until
//    every bin result has been taken.
//  - Binning reads each stored sample and uses the shared divider to find
//    its bin; a set whose min equals its max skips the divider and puts
//    every sample in the last bin.
//  - The mean is then found on the same divider after binning.
//  - Output channel (out_valid/out_ready) then gives one request per bin,
//    bin 0 first, each after its count is read; last_bin marks the final one.
//  - A stalled receiver simply holds the current result; nothing is lost.
//  - cfg_wr_en/cfg_wr_data write bin_count, sampled when binning begins;
//    write it only while loading has not begun or between sets.
//  - Samples past MAX_SAMPLES are dropped and flag overflowed.
//  - arst_n clears statistics, sets bin_count to 10, and the block is ready
//    as soon as reset is released; the sample store needs no clearing.
// ----------------------------------------------------------------------------
module sample_stats_histogram_top
	import ssh_pkg::*;
#(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
	parameter int MAX_BINS    = DEF_MAX_BINS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [BIN_COUNT_W-1:0] cfg_wr_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_W-1:0]    sample,
	input  logic                   last_sample,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [INDEX_W-1:0]     bin_index,
	output logic [TALLY_W-1:0]     bin_tally,
	output logic [SAMPLE_W-1:0]    minimum,
	output logic [SAMPLE_W-1:0]    maximum,
	output logic [SAMPLE_W-1:0]    average,
	output logic                   overflowed,
	output logic                   last_bin
);

	localparam int AW     = $clog2(MAX_SAMPLES);
	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W  = SAMPLE_W + AW;
	localparam int BW     = $clog2(MAX_BINS);
	localparam int NB_W   = $clog2(MAX_BINS + 1);
	localparam int QB     = BW + 1;
	localparam int MUL_W  = SAMPLE_W + 1 + NB_W;
	localparam int QW     = (QB > SAMPLE_W) ? QB : SAMPLE_W;
	localparam int W_AVG  = (SUM_W > CNT_W + SAMPLE_W - 1) ? SUM_W : CNT_W + SAMPLE_W - 1;
	localparam int W_BIN  = (MUL_W > SAMPLE_W + QB - 1) ? MUL_W : SAMPLE_W + QB - 1;
	localparam int DIV_W  = (W_AVG > W_BIN) ? W_AVG : W_BIN;
	localparam int SW     = $clog2(QW + 1);

	sts_t sts;
	ctl_t ctl;

	logic [BIN_COUNT_W-1:0] bin_count_q;
	logic [CNT_W-1:0]       total_q;
	logic [SAMPLE_W-1:0]    min_q;
	logic [SAMPLE_W-1:0]    max_q;
	logic [SUM_W-1:0]       sum_q;
	logic                   ovf_q;
	logic [MAX_BINS-1:0]    cnt_vld_q;

	logic [NB_W-1:0]        nb_q;
	logic [SAMPLE_W-1:0]    span_q;
	logic [CNT_W-1:0]       idx_q;
	logic [BW-1:0]          k_q;
	logic [BW-1:0]          bin_q;
	logic [MUL_W-1:0]       num_q;
	logic [SAMPLE_W-1:0]    avg_q;
	logic [SAMPLE_W-1:0]    rd_data_q;
	logic [CNT_W-1:0]       cnt_rd_q;
	logic                   vld_rd_q;

	logic [SAMPLE_W-1:0]    store_mem [MAX_SAMPLES];
	logic [CNT_W-1:0]       cnt_mem [MAX_BINS];

	logic                   in_fire;
	logic                   out_fire;
	logic                   full;
	logic                   store_wr;
	logic                   finish;
	logic [NB_W-1:0]        nb_eff;
	logic [SAMPLE_W-1:0]    diff;
	logic [MUL_W-1:0]       prod;
	logic [BW-1:0]          cnt_addr;
	logic [CNT_W-1:0]       cnt_cur;
	logic                   div_start;
	logic [DIV_W-1:0]       div_a;
	logic [DIV_W-1:0]       div_b;
	logic [SW-1:0]          div_steps;
	logic                   div_done;
	logic [QW-1:0]          div_quo;
	logic                   last_bin_w;

	assign in_fire    = in_valid && ctl.in_ready;
	assign out_fire   = ctl.out_valid && out_ready;
	assign full       = (total_q == CNT_W'(MAX_SAMPLES));
	assign store_wr   = in_fire && !full;
	assign last_bin_w = ((NB_W'(k_q) + NB_W'(1)) == nb_q);
	assign finish     = out_fire && last_bin_w;

	always_comb begin
		if (bin_count_q < BIN_COUNT_MIN) begin
			nb_eff = NB_W'(2);
		end else if (int'(bin_count_q) > MAX_BINS) begin
			nb_eff = NB_W'(MAX_BINS);
		end else begin
			nb_eff = NB_W'(bin_count_q);
		end
	end

	assign diff = rd_data_q - min_q;
	assign prod = (MUL_W'(diff) + MUL_W'(1)) * MUL_W'(nb_q);

	assign sts.in_fire   = in_fire;
	assign sts.last_in   = last_sample;
	assign sts.empty     = (total_q == '0);
	assign sts.span_zero = (span_q == '0);
	assign sts.div_done  = div_done;
	assign sts.last_idx  = ((idx_q + CNT_W'(1)) == total_q);
	assign sts.out_fire  = out_fire;
	assign sts.last_bin  = last_bin_w;

	ssh_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	assign div_start = (ctl.bin_start && !sts.span_zero) || ctl.avg_start;
	assign div_a     = ctl.avg_start ? DIV_W'(sum_q) : DIV_W'(num_q);
	assign div_b     = ctl.avg_start ? DIV_W'(total_q) : DIV_W'(span_q);
	assign div_steps = ctl.avg_start ? SW'(SAMPLE_W) : SW'(QB);

	ssh_divider #(
		.W  (DIV_W),
		.QW (QW),
		.SW (SW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.steps    (div_steps),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q <= BIN_COUNT_RST;
			total_q     <= '0;
			min_q       <= '1;
			max_q       <= '0;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			cnt_vld_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				bin_count_q <= cfg_wr_data;
			end
			if (in_fire) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					total_q <= total_q + 1'b1;
					sum_q   <= sum_q + SUM_W'(sample);
					if (sample < min_q) min_q <= sample;
					if (sample > max_q) max_q <= sample;
				end
			end
			if (ctl.setup) begin
				cnt_vld_q <= '0;
				if (sts.empty) begin
					min_q <= '0;
					max_q <= '0;
				end
			end
			if (ctl.cnt_wr) begin
				cnt_vld_q[bin_q] <= 1'b1;
			end
			if (finish) begin
				total_q <= '0;
				min_q   <= '1;
				max_q   <= '0;
				sum_q   <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.setup) begin
			nb_q   <= nb_eff;
			span_q <= max_q - min_q;
			idx_q  <= '0;
			k_q    <= '0;
			avg_q  <= '0;
		end
		if (ctl.mul) begin
			num_q <= prod - MUL_W'(1);
		end
		if (ctl.bin_start && sts.span_zero) begin
			bin_q <= BW'(nb_q - NB_W'(1));
		end
		if (ctl.bin_cap && div_done) begin
			if (div_quo >= QW'(nb_q - NB_W'(1))) begin
				bin_q <= BW'(nb_q - NB_W'(1));
			end else begin
				bin_q <= BW'(div_quo);
			end
		end
		if (ctl.cnt_wr) begin
			idx_q <= idx_q + 1'b1;
		end
		if (ctl.avg_cap && div_done) begin
			avg_q <= div_quo[SAMPLE_W-1:0];
		end
		if (out_fire && !last_bin_w) begin
			k_q <= k_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (store_wr) begin
			store_mem[total_q[AW-1:0]] <= sample;
		end
		if (ctl.rd) begin
			rd_data_q <= store_mem[idx_q[AW-1:0]];
		end
	end

	assign cnt_addr = ctl.out_rd ? k_q : bin_q;
	assign cnt_cur  = vld_rd_q ? cnt_rd_q : '0;

	always_ff @(posedge clk) begin
		if (ctl.cnt_wr) begin
			cnt_mem[bin_q] <= cnt_cur + 1'b1;
		end
		if (ctl.cnt_rd || ctl.out_rd) begin
			cnt_rd_q <= cnt_mem[cnt_addr];
			vld_rd_q <= cnt_vld_q[cnt_addr];
		end
	end

	assign in_ready   = ctl.in_ready;
	assign out_valid  = ctl.out_valid;
	assign bin_index  = INDEX_W'(k_q);
	assign bin_tally  = TALLY_W'(cnt_cur);
	assign minimum    = min_q;
	assign maximum    = max_q;
	assign average    = avg_q;
	assign overflowed = ovf_q;
	assign last_bin   = last_bin_w;

`ifndef NO_ASSERTIONS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("result pending while taking samples");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(total_q) <= MAX_SAMPLES)
		else $error("sample count past capacity");

	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cnt_wr |-> (NB_W'(bin_q) < nb_q))
		else $error("bin index beyond bin count");

	a_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_bin) |=> (in_ready && total_q == '0))
		else $error("run not cleared after final bin");
`endif

endmodule
